// ===== hdl/cdc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter package
// Field widths, request codes, reset date and the Gregorian month-length
// helpers shared by the counter modules.
// ----------------------------------------------------------------------------
package cdc_pkg;

   localparam int KIND_W  = 2;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;

   typedef enum logic [KIND_W-1:0] {
      KIND_FWD  = 2'd0,
      KIND_BACK = 2'd1,
      KIND_LOAD = 2'd2
   } kind_type;

   localparam int MAX_YEAR_DEFAULT = 9999;

   localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
   localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2021;

   localparam logic [DAY_W-1:0]   FIRST_DAY     = 5'd1;
   localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_APR     = 4'd4;
   localparam logic [MONTH_W-1:0] MONTH_JUN     = 4'd6;
   localparam logic [MONTH_W-1:0] MONTH_SEP     = 4'd9;
   localparam logic [MONTH_W-1:0] MONTH_NOV     = 4'd11;
   localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
   localparam logic [DAY_W-1:0]   DAYS_LONG     = 5'd31;
   localparam logic [DAY_W-1:0]   DAYS_SHORT    = 5'd30;
   localparam logic [DAY_W-1:0]   DAYS_FEB      = 5'd28;
   localparam logic [DAY_W-1:0]   DAYS_FEB_LEAP = 5'd29;
   localparam logic [YEAR_W-1:0]  FIRST_YEAR    = 14'd1;
   localparam logic [YEAR_W-1:0]  FALLBACK_YEAR = 14'd1900;

   // y / 25 by reciprocal: exact for every 14-bit year
   localparam int DIV25_SHIFT = 17;
   localparam int DIV25_MUL   = (2**DIV25_SHIFT + 24) / 25;
   localparam int PROD_W      = YEAR_W + 13;
   localparam int QUOT_W      = 10;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               load_ok;
   } item_type;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic               refused;
   } result_type;

   // Gregorian rule: div by 4, and not by 100 unless by 400
   function automatic logic leap_year(input logic [YEAR_W-1:0] y);
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] quot;
      logic [YEAR_W-1:0] back;
      logic              div25;
      prod  = PROD_W'(y) * PROD_W'(DIV25_MUL);
      quot  = QUOT_W'(prod >> DIV25_SHIFT);
      back  = (YEAR_W'(quot) << 4) + (YEAR_W'(quot) << 3) + YEAR_W'(quot);
      div25 = (back == y);
      return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
   endfunction

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         MONTH_FEB:                               len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default:                                 len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

// ===== hdl/cdc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter channels
// Valid/ready channels for requests and for the resulting dates.
// ----------------------------------------------------------------------------
interface cdc_req_if;
   logic                          valid;
   logic                          ready;
   logic [cdc_pkg::KIND_W-1:0]    kind;
   logic [cdc_pkg::DAY_W-1:0]     new_day;
   logic [cdc_pkg::MONTH_W-1:0]   new_month;
   logic [cdc_pkg::YEAR_W-1:0]    new_year;

   modport source (output valid, kind, new_day, new_month, new_year, input ready);
   modport sink   (input valid, kind, new_day, new_month, new_year, output ready);
endinterface

interface cdc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cdc_pkg::DAY_W-1:0]     cur_day;
   logic [cdc_pkg::MONTH_W-1:0]   cur_month;
   logic [cdc_pkg::YEAR_W-1:0]    cur_year;
   logic                          refused;

   modport source (output valid, cur_day, cur_month, cur_year, refused, input ready);
   modport sink   (input valid, cur_day, cur_month, cur_year, refused, output ready);
endinterface

// ===== hdl/cdc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter input stage
// Registers each request and pre-checks the date that a load carries.
// ----------------------------------------------------------------------------
module cdc_in_stage #(
   parameter int MAX_YEAR = cdc_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   cdc_req_if.sink             req_if,
   input  logic                take,
   output logic                item_valid,
   output cdc_pkg::item_type   item
);

   localparam logic [cdc_pkg::YEAR_W-1:0] YEAR_LIMIT = cdc_pkg::YEAR_W'(MAX_YEAR);

   logic               valid_ff, valid_in;
   cdc_pkg::item_type  item_ff, item_in;
   logic               leap;
   logic               load_ok;
   logic               xfer;

   assign req_if.ready = !valid_ff || take;
   assign xfer         = req_if.valid && req_if.ready;

   always_comb begin
      leap    = cdc_pkg::leap_year(req_if.new_year);
      load_ok = (req_if.new_year >= cdc_pkg::FIRST_YEAR) && (req_if.new_year <= YEAR_LIMIT) &&
                (req_if.new_month >= cdc_pkg::MONTH_JAN) &&
                (req_if.new_month <= cdc_pkg::MONTH_DEC) &&
                (req_if.new_day >= cdc_pkg::FIRST_DAY) &&
                (req_if.new_day <= cdc_pkg::month_length(req_if.new_month, leap));
      item_in.kind    = req_if.kind;
      item_in.day     = req_if.new_day;
      item_in.month   = req_if.new_month;
      item_in.year    = req_if.new_year;
      item_in.load_ok = load_ok;
   end

   always_comb begin
      valid_in = valid_ff;
      if (xfer) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

   // A waiting item must not vanish before the date stage takes it
   a_hold_item : assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !take) |=> (valid_ff && $stable(item_ff)))
      else $error("input stage dropped a waiting item");

endmodule

// ===== hdl/cdc_date_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter date step
// Holds the current date and applies one request to it per transfer.
// ----------------------------------------------------------------------------
module cdc_date_step #(
   parameter int MAX_YEAR = cdc_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  cdc_pkg::item_type    item,
   output cdc_pkg::result_type  res
);

   localparam logic [cdc_pkg::YEAR_W-1:0] YEAR_LIMIT = cdc_pkg::YEAR_W'(MAX_YEAR);

   logic [cdc_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [cdc_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [cdc_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic                        refused;
   logic                        leap_cur;
   logic [cdc_pkg::DAY_W-1:0]   len_cur;
   logic [cdc_pkg::DAY_W-1:0]   len_prev;
   logic [cdc_pkg::MONTH_W-1:0] month_prev;

   always_comb begin
      leap_cur   = cdc_pkg::leap_year(year_ff);
      len_cur    = cdc_pkg::month_length(month_ff, leap_cur);
      month_prev = month_ff - cdc_pkg::MONTH_W'(1);
      len_prev   = cdc_pkg::month_length(month_prev, leap_cur);
   end

   always_comb begin
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      refused  = 1'b0;
      case (cdc_pkg::kind_type'(item.kind))
         cdc_pkg::KIND_FWD: begin
            if (day_ff < len_cur) begin
               day_in = day_ff + cdc_pkg::DAY_W'(1);
            end else if (month_ff < cdc_pkg::MONTH_DEC) begin
               day_in   = cdc_pkg::FIRST_DAY;
               month_in = month_ff + cdc_pkg::MONTH_W'(1);
            end else if (year_ff >= YEAR_LIMIT) begin
               refused = 1'b1;
            end else begin
               day_in   = cdc_pkg::FIRST_DAY;
               month_in = cdc_pkg::MONTH_JAN;
               year_in  = year_ff + cdc_pkg::YEAR_W'(1);
            end
         end
         cdc_pkg::KIND_BACK: begin
            if (day_ff > cdc_pkg::FIRST_DAY) begin
               day_in = day_ff - cdc_pkg::DAY_W'(1);
            end else if (month_ff > cdc_pkg::MONTH_JAN) begin
               month_in = month_prev;
               day_in   = len_prev;
            end else begin
               // step back to December 31 of the previous year; below year one wrap to the fallback year
               month_in = cdc_pkg::MONTH_DEC;
               day_in   = cdc_pkg::DAYS_LONG;
               year_in  = (year_ff <= cdc_pkg::FIRST_YEAR) ? cdc_pkg::FALLBACK_YEAR
                                                          : year_ff - cdc_pkg::YEAR_W'(1);
            end
         end
         cdc_pkg::KIND_LOAD: begin
            if (item.load_ok) begin
               day_in   = item.day;
               month_in = item.month;
               year_in  = item.year;
            end else begin
               refused = 1'b1;
            end
         end
         default: begin
         end
      endcase
      res.day     = day_in;
      res.month   = month_in;
      res.year    = year_in;
      res.refused = refused;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         day_ff   <= cdc_pkg::RESET_DAY;
         month_ff <= cdc_pkg::RESET_MONTH;
         year_ff  <= cdc_pkg::RESET_YEAR;
      end else if (fire) begin
         day_ff   <= day_in;
         month_ff <= month_in;
         year_ff  <= year_in;
      end
   end

   a_date_sane : assert property (@(posedge clock) disable iff (reset)
      (month_ff >= cdc_pkg::MONTH_JAN) && (month_ff <= cdc_pkg::MONTH_DEC) &&
      (day_ff >= cdc_pkg::FIRST_DAY) && (day_ff <= len_cur))
      else $error("stored date is not a calendar date");

   a_refuse_holds : assert property (@(posedge clock) disable iff (reset)
      (fire && res.refused) |=> ($stable(day_ff) && $stable(month_ff) && $stable(year_ff)))
      else $error("refused request changed the date");

endmodule

// ===== hdl/cdc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter output stage
// Result register that drives the response channel.
// ----------------------------------------------------------------------------
module cdc_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  cdc_pkg::result_type  res,
   output logic                 out_free,
   cdc_rsp_if.source            rsp_if
);

   logic                 valid_ff, valid_in;
   cdc_pkg::result_type  res_ff;

   assign out_free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.cur_day   = res_ff.day;
   assign rsp_if.cur_month = res_ff.month;
   assign rsp_if.cur_year  = res_ff.year;
   assign rsp_if.refused   = res_ff.refused;

endmodule

// ===== hdl/calendar_date_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter
// Gregorian day counter: step forward, step back or load a checked date.
// ----------------------------------------------------------------------------
// Every request gives one response carrying the date after the request and a
// refused flag (invalid load, or a forward step past MAX_YEAR). A request
// enters an input register on transfer and is applied to the stored date once
// the output register is free; the response is loaded into the output register
// as the date register is updated.
// One request is taken every cycle as long as the response side keeps up.
// A stalled response holds the output register and, once the input register
// is also full, the request channel.
// ----------------------------------------------------------------------------
module calendar_date_counter_top #(
   parameter int MAX_YEAR = cdc_pkg::MAX_YEAR_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   cdc_req_if.sink    req_if,
   cdc_rsp_if.source  rsp_if
);

   logic                 item_valid;
   cdc_pkg::item_type    item;
   cdc_pkg::result_type  res;
   logic                 out_free;
   logic                 fire;

   assign fire = item_valid && out_free;

   cdc_in_stage #(
      .MAX_YEAR (MAX_YEAR)
   ) u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   cdc_date_step #(
      .MAX_YEAR (MAX_YEAR)
   ) u_date_step (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .res   (res)
   );

   cdc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .res      (res),
      .out_free (out_free),
      .rsp_if   (rsp_if)
   );

   a_fire_shows : assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_if.valid && (rsp_if.cur_year == $past(res.year))))
      else $error("applied request did not reach the response register");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date counter testbench
// Drives step-forward, step-back and load requests into the counter and checks
// every response against a date model kept in a small scoreboard class. The
// sender works in bursts and the receiver stalls in shifting patterns. One long
// receiver hold-off fills the block, and sender pauses drain it.
// ----------------------------------------------------------------------------
module testbench;

   localparam int                         YEAR_LIMIT   = cdc_pkg::MAX_YEAR_DEFAULT;
   localparam logic [cdc_pkg::KIND_W-1:0] KIND_UNUSED  = 2'd3;
   localparam int                         RANDOM_ITEMS = 450;
   localparam int                         MONTHS       = 12;

   class date_scoreboard;
      logic [cdc_pkg::DAY_W-1:0]   day_now;
      logic [cdc_pkg::MONTH_W-1:0] month_now;
      logic [cdc_pkg::YEAR_W-1:0]  year_now;
      cdc_pkg::result_type         expected_q[$];
      int                          errors;

      function new();
         day_now   = cdc_pkg::RESET_DAY;
         month_now = cdc_pkg::RESET_MONTH;
         year_now  = cdc_pkg::RESET_YEAR;
         errors    = 0;
      endfunction

      function bit is_leap(logic [cdc_pkg::YEAR_W-1:0] y);
         int yi;
         yi = y;
         return (yi % 400 == 0) || ((yi % 100 != 0) && (yi % 4 == 0));
      endfunction

      function logic [cdc_pkg::DAY_W-1:0] days_in(logic [cdc_pkg::MONTH_W-1:0] m,
                                                 logic [cdc_pkg::YEAR_W-1:0] y);
         if (m == cdc_pkg::MONTH_FEB) begin
            return is_leap(y) ? cdc_pkg::DAYS_FEB_LEAP : cdc_pkg::DAYS_FEB;
         end
         if (m == cdc_pkg::MONTH_APR || m == cdc_pkg::MONTH_JUN ||
             m == cdc_pkg::MONTH_SEP || m == cdc_pkg::MONTH_NOV) begin
            return cdc_pkg::DAYS_SHORT;
         end
         return cdc_pkg::DAYS_LONG;
      endfunction

      // apply one accepted request to the date and queue the response it gives
      function void note_request(logic [cdc_pkg::KIND_W-1:0] k,
                                 logic [cdc_pkg::DAY_W-1:0] d,
                                 logic [cdc_pkg::MONTH_W-1:0] m,
                                 logic [cdc_pkg::YEAR_W-1:0] y);
         cdc_pkg::result_type exp;
         exp.refused = 1'b0;
         case (k)
            cdc_pkg::KIND_FWD: begin
               if (day_now < days_in(month_now, year_now)) begin
                  day_now = day_now + 1'b1;
               end else if (month_now < cdc_pkg::MONTH_DEC) begin
                  day_now   = cdc_pkg::FIRST_DAY;
                  month_now = month_now + 1'b1;
               end else if (year_now >= YEAR_LIMIT) begin
                  exp.refused = 1'b1;
               end else begin
                  day_now   = cdc_pkg::FIRST_DAY;
                  month_now = cdc_pkg::MONTH_JAN;
                  year_now  = year_now + 1'b1;
               end
            end
            cdc_pkg::KIND_BACK: begin
               if (day_now > cdc_pkg::FIRST_DAY) begin
                  day_now = day_now - 1'b1;
               end else if (month_now > cdc_pkg::MONTH_JAN) begin
                  month_now = month_now - 1'b1;
                  day_now   = days_in(month_now, year_now);
               end else begin
                  month_now = cdc_pkg::MONTH_DEC;
                  day_now   = cdc_pkg::DAYS_LONG;
                  year_now  = (year_now <= cdc_pkg::FIRST_YEAR) ? cdc_pkg::FALLBACK_YEAR
                                                               : year_now - 1'b1;
               end
            end
            cdc_pkg::KIND_LOAD: begin
               if (y >= cdc_pkg::FIRST_YEAR && y <= YEAR_LIMIT &&
                   m >= cdc_pkg::MONTH_JAN && m <= cdc_pkg::MONTH_DEC &&
                   d >= cdc_pkg::FIRST_DAY && d <= days_in(m, y)) begin
                  day_now   = d;
                  month_now = m;
                  year_now  = y;
               end else begin
                  exp.refused = 1'b1;
               end
            end
            default: ;
         endcase
         exp.day   = day_now;
         exp.month = month_now;
         exp.year  = year_now;
         expected_q.push_back(exp);
      endfunction

      function void compare_field(string name, int exp, int got);
         if (exp != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, got);
            errors++;
         end
      endfunction

      function void check_result(cdc_pkg::result_type got);
         cdc_pkg::result_type exp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %0d-%0d-%0d refused %0b",
                     $time, got.year, got.month, got.day, got.refused);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         compare_field("cur_day", exp.day, got.day);
         compare_field("cur_month", exp.month, got.month);
         compare_field("cur_year", exp.year, got.year);
         compare_field("refused", exp.refused, got.refused);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   cdc_req_if req_ch ();
   cdc_rsp_if rsp_ch ();

   calendar_date_counter_top #(
      .MAX_YEAR (YEAR_LIMIT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   date_scoreboard date_sb;
   int             results_seen;
   int             burst_left;
   int             random_items;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      date_sb      = new();
      results_seen = 0;
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      cdc_pkg::result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            date_sb.note_request(req_ch.kind, req_ch.new_day, req_ch.new_month,
                                 req_ch.new_year);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.day     = rsp_ch.cur_day;
            got.month   = rsp_ch.cur_month;
            got.year    = rsp_ch.cur_year;
            got.refused = rsp_ch.refused;
            date_sb.check_result(got);
            results_seen++;
         end
      end
   end

   // receiver: shifting stall modes, plus one long hold-off
   initial begin
      int rx_cycle;
      int mode;
      int hold_left;
      bit hold_done;
      rx_cycle     = 0;
      mode         = 0;
      hold_left    = 0;
      hold_done    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (rx_cycle % 50 == 0) begin
            mode = $urandom_range(0, 3);
         end
         if (!hold_done && results_seen >= 120) begin
            hold_left = 80;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready = 1'b1;
               1:       rsp_ch.ready = (rx_cycle % 5) >= 2;
               2:       rsp_ch.ready = $urandom_range(0, 9) >= 3;
               default: rsp_ch.ready = $urandom_range(0, 9) >= 7;
            endcase
         end
      end
   end

   // offer one request at the falling edge, hold it until transfer, and pause after a burst
   task automatic send_item(logic [cdc_pkg::KIND_W-1:0] k, logic [cdc_pkg::DAY_W-1:0] d,
                            logic [cdc_pkg::MONTH_W-1:0] m,
                            logic [cdc_pkg::YEAR_W-1:0] y);
      req_ch.kind      = k;
      req_ch.new_day   = d;
      req_ch.new_month = m;
      req_ch.new_year  = y;
      req_ch.valid     = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      if (k != KIND_UNUSED) begin
         random_items++;
      end
      burst_left--;
      if (burst_left <= 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 20);
      end
   endtask

   task automatic drain_pause();
      req_ch.valid = 1'b0;
      while (date_sb.pending() > 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [cdc_pkg::YEAR_W-1:0] pick_year();
      case ($urandom_range(0, 9))
         0:       return cdc_pkg::FIRST_YEAR;
         1:       return 14'd2;
         2:       return cdc_pkg::YEAR_W'(YEAR_LIMIT);
         3:       return cdc_pkg::YEAR_W'(YEAR_LIMIT - 1);
         4:       return cdc_pkg::FALLBACK_YEAR;
         5:       return 14'd2000;
         6:       return cdc_pkg::YEAR_W'(4 * $urandom_range(1, YEAR_LIMIT / 4));
         7:       return cdc_pkg::YEAR_W'(100 * $urandom_range(1, YEAR_LIMIT / 100));
         default: return cdc_pkg::YEAR_W'($urandom_range(1, YEAR_LIMIT));
      endcase
   endfunction

   // valid load, biased toward the month starts and ends where steps cross boundaries
   task automatic load_valid_date();
      logic [cdc_pkg::YEAR_W-1:0]  y;
      logic [cdc_pkg::MONTH_W-1:0] m;
      logic [cdc_pkg::DAY_W-1:0]   len;
      logic [cdc_pkg::DAY_W-1:0]   d;
      y   = pick_year();
      m   = cdc_pkg::MONTH_W'($urandom_range(1, MONTHS));
      len = date_sb.days_in(m, y);
      case ($urandom_range(0, 3))
         0:       d = cdc_pkg::FIRST_DAY;
         1:       d = len;
         2:       d = len - 1'b1;
         default: d = cdc_pkg::DAY_W'($urandom_range(1, len));
      endcase
      send_item(cdc_pkg::KIND_LOAD, d, m, y);
   endtask

   task automatic load_broken_date();
      logic [cdc_pkg::YEAR_W-1:0]  y;
      logic [cdc_pkg::MONTH_W-1:0] m;
      logic [cdc_pkg::DAY_W-1:0]   d;
      y = pick_year();
      m = cdc_pkg::MONTH_W'($urandom_range(1, MONTHS));
      d = cdc_pkg::DAY_W'($urandom_range(1, date_sb.days_in(m, y)));
      case ($urandom_range(0, 4))
         0: y = '0;
         1: m = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
         2: d = '0;
         3: d = (date_sb.days_in(m, y) < cdc_pkg::DAYS_LONG)
                ? 5'($urandom_range(date_sb.days_in(m, y) + 1, 31)) : 5'd0;
         default: begin
            d = cdc_pkg::DAY_W'($urandom_range(0, 31));
            m = cdc_pkg::MONTH_W'($urandom_range(0, 15));
            y = cdc_pkg::YEAR_W'($urandom_range(0, YEAR_LIMIT));
         end
      endcase
      send_item(cdc_pkg::KIND_LOAD, d, m, y);
   endtask

   task automatic step_run(int count);
      int                         dir;
      logic [cdc_pkg::KIND_W-1:0] k;
      dir = $urandom_range(0, 2);
      repeat (count) begin
         if (dir == 2) begin
            k = ($urandom_range(0, 1) == 0) ? cdc_pkg::KIND_FWD : cdc_pkg::KIND_BACK;
         end else begin
            k = (dir == 0) ? cdc_pkg::KIND_FWD : cdc_pkg::KIND_BACK;
         end
         send_item(k, cdc_pkg::DAY_W'($urandom_range(0, 31)),
                   cdc_pkg::MONTH_W'($urandom_range(0, 15)),
                   cdc_pkg::YEAR_W'($urandom_range(0, YEAR_LIMIT)));
      end
   endtask

   initial begin
      int  pick;
      bit  drained;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.kind      = cdc_pkg::KIND_FWD;
      req_ch.new_day   = '0;
      req_ch.new_month = '0;
      req_ch.new_year  = '0;
      random_items     = 0;
      burst_left       = 4;
      drained          = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // steps from the reset date, then across the start of the year
      send_item(cdc_pkg::KIND_FWD, '0, '0, '0);
      send_item(cdc_pkg::KIND_BACK, '0, '0, '0);
      send_item(cdc_pkg::KIND_BACK, 5'd31, 4'd15, 14'd9999);
      // leap rules: by 4, not by 100, by 400
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::DAYS_FEB_LEAP, cdc_pkg::MONTH_FEB, 14'd2020);
      send_item(cdc_pkg::KIND_FWD, '0, '0, '0);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::DAYS_FEB_LEAP, cdc_pkg::MONTH_FEB,
                cdc_pkg::FALLBACK_YEAR);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::DAYS_FEB_LEAP, cdc_pkg::MONTH_FEB, 14'd2000);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::DAYS_FEB, cdc_pkg::MONTH_FEB, 14'd2100);
      send_item(cdc_pkg::KIND_FWD, '0, '0, '0);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::FIRST_DAY, 4'd3, 14'd2024);
      send_item(cdc_pkg::KIND_BACK, '0, '0, '0);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::FIRST_DAY, 4'd3, 14'd2023);
      send_item(cdc_pkg::KIND_BACK, '0, '0, '0);
      // forward past the year limit holds the date
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::DAYS_LONG, cdc_pkg::MONTH_DEC,
                cdc_pkg::YEAR_W'(YEAR_LIMIT));
      send_item(cdc_pkg::KIND_FWD, '0, '0, '0);
      send_item(cdc_pkg::KIND_BACK, '0, '0, '0);
      // back from the first day of year one falls to the fallback year
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::FIRST_DAY, cdc_pkg::MONTH_JAN,
                cdc_pkg::FIRST_YEAR);
      send_item(cdc_pkg::KIND_BACK, '0, '0, '0);
      // refused loads, then one valid load in a high year
      send_item(cdc_pkg::KIND_LOAD, 5'd0, 4'd5, 14'd2000);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::DAYS_LONG, cdc_pkg::MONTH_APR, 14'd2000);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::FIRST_DAY, 4'd0, 14'd2000);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::FIRST_DAY, 4'd13, 14'd2000);
      send_item(cdc_pkg::KIND_LOAD, 5'd31, 4'd15, 14'd9999);
      send_item(cdc_pkg::KIND_LOAD, cdc_pkg::FIRST_DAY, cdc_pkg::MONTH_JAN, 14'd0);
      send_item(cdc_pkg::KIND_LOAD, 5'd30, 4'd7, 14'd8191);
      // unused code leaves the date alone
      send_item(KIND_UNUSED, 5'd31, 4'd15, 14'd9999);
      drain_pause();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (!drained && random_items >= 250) begin
            drain_pause();
            drained = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            load_valid_date();
            step_run($urandom_range(1, 8));
         end else if (pick < 80) begin
            step_run($urandom_range(1, 6));
         end else if (pick < 95) begin
            load_broken_date();
         end else begin
            send_item(KIND_UNUSED, cdc_pkg::DAY_W'($urandom_range(0, 31)),
                      cdc_pkg::MONTH_W'($urandom_range(0, 15)),
                      cdc_pkg::YEAR_W'($urandom_range(0, YEAR_LIMIT)));
         end
      end

      req_ch.valid = 1'b0;
      while (date_sb.pending() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (date_sb.errors == 0 && date_sb.pending() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("%0t: timeout, %0d responses outstanding", $time, date_sb.pending());
      $display("testbench: errors");
      $finish;
   end

endmodule
